>>> sv/phb_pkg.sv
// Shared types and constants for the Potts heat-bath site update block.
// Payload structs, configuration bundle, register indexes, and the
// command/status structs between controller and datapath. No dependencies.
package phb_pkg;

  localparam int unsigned SITE_W      = 16;
  localparam int unsigned COLOR_W     = 3;
  localparam int unsigned RAND_BITS   = 16;
  localparam int unsigned WEIGHT_BITS = 24;
  localparam int unsigned MAX_SITES   = 65536;
  localparam int unsigned MAX_COLORS  = 8;

  localparam int unsigned NCOLOR_W    = 4;
  localparam int unsigned ROW_W       = 16;
  localparam int unsigned COUNT_W     = SITE_W + 1;
  localparam int unsigned WREG_W      = WEIGHT_BITS + 1;
  localparam int unsigned NUM_WEIGHTS = 5;
  localparam int unsigned MATCH_W     = 3;
  localparam int unsigned CIDX_W      = $clog2(MAX_COLORS);
  localparam int unsigned TOTAL_W     = WREG_W + CIDX_W;
  localparam int unsigned PROD_W      = RAND_BITS + TOTAL_W;
  localparam int unsigned NUM_NBRS    = 4;
  localparam int unsigned RDCNT_W     = 3;
  localparam int unsigned REMCNT_W    = $clog2(SITE_W + 1);

  localparam int unsigned PADDR_W     = 5;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [NCOLOR_W-1:0] NUM_COLORS_RST = 4'd2;
  localparam logic [ROW_W-1:0]    ROW_WIDTH_RST  = 16'd256;
  localparam logic [COUNT_W-1:0]  SITE_COUNT_RST = 17'd65536;
  localparam logic [WREG_W-1:0]   WEIGHT_RST     = 25'd16777216;

  typedef enum logic [2:0] {
    REG_NUM_COLORS   = 3'd0,
    REG_ROW_WIDTH    = 3'd1,
    REG_SITE_COUNT   = 3'd2,
    REG_WEIGHT_ZERO  = 3'd3,
    REG_WEIGHT_ONE   = 3'd4,
    REG_WEIGHT_TWO   = 3'd5,
    REG_WEIGHT_THREE = 3'd6,
    REG_WEIGHT_FOUR  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic                 action;
    logic [SITE_W-1:0]    site;
    logic [COLOR_W-1:0]   color;
    logic [RAND_BITS-1:0] rand_fraction;
  } in_item_t;

  typedef struct packed {
    logic [SITE_W-1:0]  site_out;
    logic [COLOR_W-1:0] color_now;
    logic               changed;
  } out_item_t;

  typedef struct packed {
    logic [NCOLOR_W-1:0]                 num_colors;
    logic [ROW_W-1:0]                    row_width;
    logic [COUNT_W-1:0]                  site_count;
    logic [NUM_WEIGHTS-1:0][WREG_W-1:0]  weight;
  } cfg_t;

  typedef struct packed {
    logic item_load;
    logic rem_start;
    logic rem_sel_row;
    logic idx_load;
    logic w_load;
    logic rd_clear;
    logic rd_issue;
    logic sum_clear;
    logic sum_step;
    logic mult;
    logic sel_clear;
    logic sel_step;
    logic ram_write;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic rem_busy;
    logic rd_last;
    logic col_last;
    logic sel_hit;
    logic out_free;
  } status_t;

endpackage

>>> sv/phb_ram.sv
// Generic single-port RAM, one read or one write per cycle, registered read.
// No dependencies.
module phb_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/phb_regs.sv
// APB-style configuration registers: colour count, row width, site count
// and the five neighbour weights. Depends on phb_pkg.
module phb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [phb_pkg::PADDR_W-1:0] paddr,
  input  logic [phb_pkg::PDATA_W-1:0] pwdata,
  output logic [phb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output phb_pkg::cfg_t               cfg_o
);

  phb_pkg::cfg_t     cfg_q;
  phb_pkg::reg_idx_e reg_idx;
  logic              wr_en;

  assign reg_idx = phb_pkg::reg_idx_e'(paddr[phb_pkg::PADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_colors <= phb_pkg::NUM_COLORS_RST;
      cfg_q.row_width  <= phb_pkg::ROW_WIDTH_RST;
      cfg_q.site_count <= phb_pkg::SITE_COUNT_RST;
      cfg_q.weight     <= {phb_pkg::NUM_WEIGHTS{phb_pkg::WEIGHT_RST}};
    end else if (wr_en) begin
      case (reg_idx)
        phb_pkg::REG_NUM_COLORS:   cfg_q.num_colors <= pwdata[phb_pkg::NCOLOR_W-1:0];
        phb_pkg::REG_ROW_WIDTH:    cfg_q.row_width  <= pwdata[phb_pkg::ROW_W-1:0];
        phb_pkg::REG_SITE_COUNT:   cfg_q.site_count <= pwdata[phb_pkg::COUNT_W-1:0];
        phb_pkg::REG_WEIGHT_ZERO:  cfg_q.weight[0]  <= pwdata[phb_pkg::WREG_W-1:0];
        phb_pkg::REG_WEIGHT_ONE:   cfg_q.weight[1]  <= pwdata[phb_pkg::WREG_W-1:0];
        phb_pkg::REG_WEIGHT_TWO:   cfg_q.weight[2]  <= pwdata[phb_pkg::WREG_W-1:0];
        phb_pkg::REG_WEIGHT_THREE: cfg_q.weight[3]  <= pwdata[phb_pkg::WREG_W-1:0];
        phb_pkg::REG_WEIGHT_FOUR:  cfg_q.weight[4]  <= pwdata[phb_pkg::WREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      phb_pkg::REG_NUM_COLORS:   prdata = phb_pkg::PDATA_W'(cfg_q.num_colors);
      phb_pkg::REG_ROW_WIDTH:    prdata = phb_pkg::PDATA_W'(cfg_q.row_width);
      phb_pkg::REG_SITE_COUNT:   prdata = phb_pkg::PDATA_W'(cfg_q.site_count);
      phb_pkg::REG_WEIGHT_ZERO:  prdata = phb_pkg::PDATA_W'(cfg_q.weight[0]);
      phb_pkg::REG_WEIGHT_ONE:   prdata = phb_pkg::PDATA_W'(cfg_q.weight[1]);
      phb_pkg::REG_WEIGHT_TWO:   prdata = phb_pkg::PDATA_W'(cfg_q.weight[2]);
      phb_pkg::REG_WEIGHT_THREE: prdata = phb_pkg::PDATA_W'(cfg_q.weight[3]);
      phb_pkg::REG_WEIGHT_FOUR:  prdata = phb_pkg::PDATA_W'(cfg_q.weight[4]);
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/phb_ctrl.sv
// Sequencing state machine for one load or update transaction.
// Drives datapath commands from status; depends on phb_pkg.
module phb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  phb_pkg::status_t st_i,
  output logic             in_ready_o,
  output phb_pkg::cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_RED_SITE = 10'b00_0000_0010,
    ST_RED_ROW  = 10'b00_0000_0100,
    ST_READ     = 10'b00_0000_1000,
    ST_RD_WAIT  = 10'b00_0001_0000,
    ST_SUM      = 10'b00_0010_0000,
    ST_MULT     = 10'b00_0100_0000,
    ST_SELECT   = 10'b00_1000_0000,
    ST_WRITE    = 10'b01_0000_0000,
    ST_DONE     = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          cmd_o.rem_start = 1'b1;
          state_d         = ST_RED_SITE;
        end
      end
      ST_RED_SITE: begin
        if (!st_i.rem_busy) begin
          cmd_o.idx_load = 1'b1;
          cmd_o.rd_clear = 1'b1;
          if (st_i.action) begin
            cmd_o.rem_start   = 1'b1;
            cmd_o.rem_sel_row = 1'b1;
            state_d           = ST_RED_ROW;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_RED_ROW: begin
        if (!st_i.rem_busy) begin
          cmd_o.w_load = 1'b1;
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        if (st_i.rd_last) begin
          state_d = ST_RD_WAIT;
        end
      end
      ST_RD_WAIT: begin
        cmd_o.sum_clear = 1'b1;
        state_d         = st_i.action ? ST_SUM : ST_WRITE;
      end
      ST_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (st_i.col_last) begin
          state_d = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd_o.mult      = 1'b1;
        cmd_o.sel_clear = 1'b1;
        state_d         = ST_SELECT;
      end
      ST_SELECT: begin
        cmd_o.sel_step = 1'b1;
        // zero total weight: no colour qualifies, keep the old one
        if (st_i.sel_hit) begin
          state_d = ST_WRITE;
        end else if (st_i.col_last) begin
          state_d = ST_DONE;
        end
      end
      ST_WRITE: begin
        cmd_o.ram_write = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/phb_dp.sv
// Datapath: bit-serial remainder, neighbour addressing, lattice RAM,
// per-colour weight accumulation and selection, output register.
// Depends on phb_pkg and phb_ram.
module phb_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  phb_pkg::cfg_t       cfg_i,
  input  phb_pkg::in_item_t   in_item_i,
  input  phb_pkg::cmd_t       cmd_i,
  output phb_pkg::status_t    st_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output phb_pkg::out_item_t  out_item_o
);

  localparam int unsigned SW = phb_pkg::SITE_W;
  localparam int unsigned NW = phb_pkg::COUNT_W;
  localparam int unsigned CW = phb_pkg::COLOR_W;

  // item registers
  logic                          action_q;
  logic [CW-1:0]                 color_q;
  logic [phb_pkg::RAND_BITS-1:0] rand_q;

  // effective site count and colour count
  logic [NW-1:0]               n_eff;
  logic [phb_pkg::NCOLOR_W-1:0] ncol_eff;
  logic [phb_pkg::CIDX_W-1:0]  ncol_m1;

  // remainder unit
  logic [SW-1:0]                 rem_a, a_q;
  logic [NW-1:0]                 rem_q;
  logic [phb_pkg::REMCNT_W-1:0]  rem_cnt_q;
  logic [NW:0]                   rem_t;

  logic [SW-1:0] idx_q, w_q;

  // neighbours
  logic [NW-1:0] nb_up, nb_dn, nb_lt, nb_rt;
  logic [NW-1:0] idx_ext, w_ext;

  // reads
  logic [phb_pkg::RDCNT_W-1:0] rd_cnt_q, rd_slot_q;
  logic                        rd_pend_q;
  logic [SW-1:0]               rd_addr, ram_addr;
  logic [CW-1:0]               ram_rdata;
  logic [CW-1:0]               old_q, nc_q;
  logic [phb_pkg::NUM_NBRS-1:0][CW-1:0] nbc_q;

  // colour loop
  logic [phb_pkg::CIDX_W-1:0]  c_q;
  logic [phb_pkg::MATCH_W-1:0] match_cnt;
  logic [phb_pkg::WREG_W-1:0]  wsel;
  logic [phb_pkg::TOTAL_W-1:0] total_q, run_q, run_d;
  logic [phb_pkg::PROD_W-1:0]  prod_q;
  logic                        sel_hit;

  phb_pkg::out_item_t out_item_q;
  logic               out_valid_q;

  always_comb begin
    if (cfg_i.site_count == '0 ||
        (cfg_i.site_count[NW-1] && (cfg_i.site_count[NW-2:0] != '0))) begin
      n_eff = NW'(phb_pkg::MAX_SITES);
    end else begin
      n_eff = cfg_i.site_count;
    end
    if (cfg_i.num_colors == '0) begin
      ncol_eff = phb_pkg::NCOLOR_W'(1);
    end else if (cfg_i.num_colors > phb_pkg::NCOLOR_W'(phb_pkg::MAX_COLORS)) begin
      ncol_eff = phb_pkg::NCOLOR_W'(phb_pkg::MAX_COLORS);
    end else begin
      ncol_eff = cfg_i.num_colors;
    end
  end

  assign ncol_m1 = phb_pkg::CIDX_W'(ncol_eff - phb_pkg::NCOLOR_W'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      action_q <= in_item_i.action;
      color_q  <= in_item_i.color;
      rand_q   <= in_item_i.rand_fraction;
    end
  end

  // Restoring remainder, one dividend bit a cycle; skip when already below n.
  assign rem_a = cmd_i.rem_sel_row ? cfg_i.row_width : in_item_i.site;
  assign rem_t = {rem_q, a_q[SW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_cnt_q <= '0;
    end else if (cmd_i.rem_start) begin
      rem_cnt_q <= ({1'b0, rem_a} < n_eff) ? '0 : phb_pkg::REMCNT_W'(SW);
    end else if (rem_cnt_q != '0) begin
      rem_cnt_q <= rem_cnt_q - phb_pkg::REMCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rem_start) begin
      a_q   <= rem_a;
      rem_q <= ({1'b0, rem_a} < n_eff) ? NW'(rem_a) : '0;
    end else if (rem_cnt_q != '0) begin
      a_q   <= {a_q[SW-2:0], 1'b0};
      rem_q <= (rem_t >= {1'b0, n_eff}) ? NW'(rem_t - {1'b0, n_eff}) : NW'(rem_t);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_load) begin
      idx_q <= rem_q[SW-1:0];
    end
    if (cmd_i.w_load) begin
      w_q <= rem_q[SW-1:0];
    end
  end

  // Wrapped neighbour indexes; idx and w are both below n.
  assign idx_ext = {1'b0, idx_q};
  assign w_ext   = {1'b0, w_q};

  always_comb begin
    nb_up = idx_ext + w_ext;
    if (nb_up >= n_eff) begin
      nb_up = nb_up - n_eff;
    end
    nb_dn = (idx_ext >= w_ext) ? (idx_ext - w_ext) : (idx_ext + n_eff - w_ext);
    nb_lt = (idx_q == '0) ? (n_eff - NW'(1)) : (idx_ext - NW'(1));
    nb_rt = ((idx_ext + NW'(1)) == n_eff) ? '0 : (idx_ext + NW'(1));
  end

  always_comb begin
    case (rd_cnt_q)
      3'd1:    rd_addr = nb_up[SW-1:0];
      3'd2:    rd_addr = nb_dn[SW-1:0];
      3'd3:    rd_addr = nb_lt[SW-1:0];
      3'd4:    rd_addr = nb_rt[SW-1:0];
      default: rd_addr = idx_q;
    endcase
  end

  assign ram_addr = cmd_i.ram_write ? idx_q : rd_addr;

  phb_ram #(
    .WIDTH (CW),
    .DEPTH (phb_pkg::MAX_SITES)
  ) u_lattice (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_write),
    .addr_i  (ram_addr),
    .wdata_i (nc_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q  <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd_issue;
      if (cmd_i.rd_clear) begin
        rd_cnt_q <= '0;
      end else if (cmd_i.rd_issue) begin
        rd_cnt_q <= rd_cnt_q + phb_pkg::RDCNT_W'(1);
      end
    end
  end

  // Slot 0 is the site itself, slots 1 to 4 are the neighbours.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_slot_q <= rd_cnt_q;
    end
    if (rd_pend_q) begin
      if (rd_slot_q == '0) begin
        old_q <= ram_rdata;
        nc_q  <= action_q ? ram_rdata : color_q;
      end else begin
        nbc_q[2'(rd_slot_q - phb_pkg::RDCNT_W'(1))] <= ram_rdata;
      end
    end else if (cmd_i.sel_step && sel_hit) begin
      nc_q <= CW'(c_q);
    end
  end

  // Matches of colour c among the four neighbours; stray colours match nothing.
  always_comb begin
    match_cnt = '0;
    for (int k = 0; k < phb_pkg::NUM_NBRS; k++) begin
      if (nbc_q[k] == CW'(c_q)) begin
        match_cnt = match_cnt + phb_pkg::MATCH_W'(1);
      end
    end
  end

  assign wsel    = cfg_i.weight[match_cnt];
  assign run_d   = run_q + phb_pkg::TOTAL_W'(wsel);
  assign sel_hit = prod_q < {run_d, {phb_pkg::RAND_BITS{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_clear) begin
      c_q     <= '0;
      total_q <= '0;
    end else if (cmd_i.sum_step) begin
      c_q     <= c_q + phb_pkg::CIDX_W'(1);
      total_q <= total_q + phb_pkg::TOTAL_W'(wsel);
    end else if (cmd_i.sel_clear) begin
      c_q   <= '0;
      run_q <= '0;
    end else if (cmd_i.sel_step) begin
      c_q   <= c_q + phb_pkg::CIDX_W'(1);
      run_q <= run_d;
    end
    if (cmd_i.mult) begin
      prod_q <= phb_pkg::PROD_W'(rand_q) * phb_pkg::PROD_W'(total_q);
    end
  end

  // Output register: the next transaction may start while this one waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_item_q.site_out  <= idx_q;
      out_item_q.color_now <= nc_q;
      out_item_q.changed   <= (nc_q != old_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign st_o.action   = action_q;
  assign st_o.rem_busy = (rem_cnt_q != '0);
  assign st_o.rd_last  = action_q ? (rd_cnt_q == phb_pkg::RDCNT_W'(phb_pkg::NUM_NBRS))
                                  : (rd_cnt_q == '0);
  assign st_o.col_last = (c_q == ncol_m1);
  assign st_o.sel_hit  = sel_hit;
  assign st_o.out_free = !out_valid_q || out_ready_i;

endmodule

>>> sv/potts_heat_bath_site_update.sv
// Top level of the Potts heat-bath site update: registers, controller and
// datapath (with lattice RAM). Depends on phb_pkg, phb_regs, phb_ctrl, phb_dp.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o   in_item_i   (action, site, color, rand)
//   out       output     out_valid_o/out_ready_i out_item_o  (site_out, color_now, changed)
//   config    input      psel/penable/pwrite     paddr, pwdata, prdata
//
// One transaction at a time. An update steps through the colours in use, ending
// the select pass early when an early colour is picked, and the controller returns
// to idle before the next transaction is taken; each index reduction that is not
// already below the site count runs through the bit-serial remainder unit. The
// single lattice RAM port sets the five serial reads of an update.
// Reset sets control and configuration to reset values; lattice contents are undefined.
// A stalled output holds in its register while the next transaction runs.
module potts_heat_bath_site_update (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  phb_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output phb_pkg::out_item_t          out_item_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [phb_pkg::PADDR_W-1:0] paddr,
  input  logic [phb_pkg::PDATA_W-1:0] pwdata,
  output logic [phb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  phb_pkg::cfg_t    cfg;
  phb_pkg::cmd_t    cmd;
  phb_pkg::status_t st;

  phb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  phb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .st_i       (st),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  phb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while previous transaction still running");

  a_write_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ram_write |-> !in_ready_o)
    else $error("lattice write outside a transaction");

  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result overwrote an untaken result");

  a_rem_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rem_start |-> !st.rem_busy)
    else $error("remainder restarted while busy");

endmodule

>>> tb/sv/tb.sv
// Self-checking bench for potts_heat_bath_site_update: a scoreboard class predicts each
// result from its own lattice copy and register shadow; plain tasks drive the input
// channel and the APB port. Depends on phb_pkg and the block's RTL.
module tb;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned UPDATE_PCT     = 75;

  typedef struct {
    phb_pkg::out_item_t item;
    bit                 changed_known; // clear when the previous colour was never written: changed is then undefined
  } site_result_t;

  class site_update_book;
    logic [phb_pkg::NCOLOR_W-1:0] colours;
    logic [phb_pkg::ROW_W-1:0]    row_w;
    logic [phb_pkg::COUNT_W-1:0]  sites;
    logic [phb_pkg::WREG_W-1:0]   weight [phb_pkg::NUM_WEIGHTS];
    logic [phb_pkg::COLOR_W-1:0]  mem [phb_pkg::MAX_SITES];
    bit                           known [phb_pkg::MAX_SITES];
    site_result_t                 due [$];
    int unsigned                  errors;

    function new();
      colours = phb_pkg::NUM_COLORS_RST;
      row_w   = phb_pkg::ROW_WIDTH_RST;
      sites   = phb_pkg::SITE_COUNT_RST;
      foreach (weight[k]) weight[k] = phb_pkg::WEIGHT_RST;
      foreach (mem[s]) begin
        mem[s]   = '0;
        known[s] = 1'b0;
      end
      errors = 0;
    endfunction

    function void set_reg(phb_pkg::reg_idx_e r, logic [phb_pkg::PDATA_W-1:0] v);
      case (r)
        phb_pkg::REG_NUM_COLORS: colours = v[phb_pkg::NCOLOR_W-1:0];
        phb_pkg::REG_ROW_WIDTH:  row_w   = v[phb_pkg::ROW_W-1:0];
        phb_pkg::REG_SITE_COUNT: sites   = v[phb_pkg::COUNT_W-1:0];
        default: weight[int'(r) - int'(phb_pkg::REG_WEIGHT_ZERO)] = v[phb_pkg::WREG_W-1:0];
      endcase
    endfunction

    function int unsigned eff_sites();
      if (sites == 0 || sites > phb_pkg::MAX_SITES) return phb_pkg::MAX_SITES;
      return int'(sites);
    endfunction

    function int unsigned eff_colours();
      if (colours > phb_pkg::MAX_COLORS) return phb_pkg::MAX_COLORS;
      if (colours == 0) return 1;
      return int'(colours);
    endfunction

    function int unsigned nbr(int unsigned idx, int unsigned k);
      int unsigned n;
      int unsigned w;
      n = eff_sites();
      w = row_w % n;
      case (k)
        0:       return (idx + w) % n;
        1:       return (idx + n - w) % n;
        2:       return (idx + n - 1) % n;
        default: return (idx + 1) % n;
      endcase
    endfunction

    // An update may only touch sites that have been loaded
    function bit ready(int unsigned raw);
      int unsigned idx;
      bit ok;
      idx = raw % eff_sites();
      ok = known[idx];
      for (int unsigned k = 0; k < phb_pkg::NUM_NBRS; k++) ok &= known[nbr(idx, k)];
      return ok;
    endfunction

    function void note_input(phb_pkg::in_item_t it);
      int unsigned n;
      int unsigned idx;
      int unsigned ncol;
      int unsigned cnt;
      int unsigned c;
      int unsigned k;
      bit found;
      logic [63:0] total;
      logic [63:0] frac;
      logic [63:0] run_sum [phb_pkg::MAX_COLORS];
      logic [phb_pkg::COLOR_W-1:0] prev;
      logic [phb_pkg::COLOR_W-1:0] now;
      site_result_t res;
      n    = eff_sites();
      idx  = it.site % n;
      prev = mem[idx];
      now  = prev;
      res.changed_known = known[idx];
      if (it.action == ACT_LOAD) begin
        now        = it.color;
        mem[idx]   = now;
        known[idx] = 1'b1;
      end else begin
        ncol  = eff_colours();
        total = '0;
        frac  = 64'(it.rand_fraction);
        for (c = 0; c < ncol; c++) begin
          cnt = 0;
          for (k = 0; k < phb_pkg::NUM_NBRS; k++) if (mem[nbr(idx, k)] == c) cnt++;
          total += 64'(weight[cnt]);
          run_sum[c] = total;
        end
        // first colour whose running sum clears rand * total; none if all weights are zero
        found = 1'b0;
        for (c = 0; c < ncol; c++) begin
          if (!found && (frac * total < (run_sum[c] << phb_pkg::RAND_BITS))) begin
            found    = 1'b1;
            now      = phb_pkg::COLOR_W'(c);
            mem[idx] = now;
          end
        end
      end
      res.item.site_out  = phb_pkg::SITE_W'(idx);
      res.item.color_now = now;
      res.item.changed   = (now != prev);
      due = {due, res};
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_result(phb_pkg::out_item_t got);
      site_result_t want;
      if (due.size() == 0) begin
        report("unexpected result, site_out", 0, got.site_out);
        return;
      end
      want = due.pop_front();
      if (got.site_out !== want.item.site_out)
        report("site_out", want.item.site_out, got.site_out);
      if (got.color_now !== want.item.color_now)
        report("color_now", want.item.color_now, got.color_now);
      if (want.changed_known && got.changed !== want.item.changed)
        report("changed", want.item.changed, got.changed);
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  phb_pkg::in_item_t             in_item_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  phb_pkg::out_item_t            out_item_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [phb_pkg::PADDR_W-1:0]   paddr;
  logic [phb_pkg::PDATA_W-1:0]   pwdata;
  logic [phb_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  site_update_book book;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     items_sent;
  int unsigned     quiet_cycles;
  bit              hold_req;
  bit              hold_done;

  potts_heat_bath_site_update dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample both channels mid-cycle, when everything driven at the edge has settled
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) book.note_input(in_item_i);
      if (out_valid_o && out_ready_i) book.check_result(out_item_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_item(input phb_pkg::in_item_t it);
    if (items_sent < 450) begin
      send_idle_pct = 10;
      recv_idle_pct = 81;
    end else if (items_sent < 900) begin
      send_idle_pct = 81;
      recv_idle_pct = 10;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (book.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input phb_pkg::reg_idx_e r,
                           input logic [phb_pkg::PDATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= phb_pkg::PADDR_W'(4 * int'(r));
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    book.set_reg(r, v);
  endtask

  task automatic configure(input int unsigned colours, row, count,
                           input int unsigned w0, w1, w2, w3, w4);
    reg_write(phb_pkg::REG_NUM_COLORS, colours);
    reg_write(phb_pkg::REG_ROW_WIDTH, row);
    reg_write(phb_pkg::REG_SITE_COUNT, count);
    reg_write(phb_pkg::REG_WEIGHT_ZERO, w0);
    reg_write(phb_pkg::REG_WEIGHT_ONE, w1);
    reg_write(phb_pkg::REG_WEIGHT_TWO, w2);
    reg_write(phb_pkg::REG_WEIGHT_THREE, w3);
    reg_write(phb_pkg::REG_WEIGHT_FOUR, w4);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic phb_pkg::in_item_t site_op(logic act, int unsigned site,
                                                int unsigned colour, int unsigned frac);
    phb_pkg::in_item_t it;
    it.action        = act;
    it.site          = phb_pkg::SITE_W'(site);
    it.color         = phb_pkg::COLOR_W'(colour);
    it.rand_fraction = phb_pkg::RAND_BITS'(frac);
    return it;
  endfunction

  // Mostly colours in use, now and then a stray one
  function automatic int unsigned pick_colour();
    if ($urandom_range(99) < 80) return $urandom_range(book.eff_colours() - 1);
    return $urandom_range(phb_pkg::MAX_COLORS - 1);
  endfunction

  // Whole lattice loaded: half the indexes unreduced, to exercise the modulo
  function automatic int unsigned pick_site(int unsigned win);
    if (win >= book.eff_sites() && $urandom_range(1)) return $urandom_range(65535);
    return $urandom_range(win - 1);
  endfunction

  task automatic fill_lattice(input int unsigned count);
    for (int unsigned s = 0; s < count; s++)
      push_item(site_op(ACT_LOAD, s, pick_colour(), $urandom_range(65535)));
  endtask

  task automatic churn(input int unsigned count, input int unsigned win);
    phb_pkg::in_item_t it;
    int unsigned       tries;
    for (int unsigned i = 0; i < count; i++) begin
      it = site_op(ACT_LOAD, pick_site(win), pick_colour(), $urandom_range(65535));
      if ($urandom_range(99) < UPDATE_PCT) begin
        tries = 0;
        while (!book.ready(it.site) && tries < 8) begin
          it.site = phb_pkg::SITE_W'(pick_site(win));
          tries++;
        end
        if (book.ready(it.site)) it.action = ACT_UPDATE;
      end
      push_item(it);
    end
  endtask

  initial begin
    book          = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent    = 0;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: build a cross around site 0, which wraps both ways
    push_item(site_op(ACT_LOAD, 0, 0, 0));
    push_item(site_op(ACT_LOAD, 65535, 7, 65535));
    push_item(site_op(ACT_LOAD, 1, 1, 0));
    push_item(site_op(ACT_LOAD, 256, 1, 0));
    push_item(site_op(ACT_LOAD, 65280, 0, 0));
    push_item(site_op(ACT_UPDATE, 0, 7, 0));
    push_item(site_op(ACT_UPDATE, 0, 0, 65535));
    push_item(site_op(ACT_LOAD, 0, 1, 0));
    push_item(site_op(ACT_LOAD, 0, 5, 0));
    push_item(site_op(ACT_UPDATE, 0, 0, 32768));
    push_item(site_op(ACT_LOAD, 65535, 7, 0));
    wait_quiet();

    configure(3, 8, 64, 16777216, 9000000, 4000000, 1500000, 500000);
    fill_lattice(64);
    churn(170, 64);
    wait_quiet();

    // Row wider than the lattice, weights at the top of the register
    configure(8, 65535, 100, 33554431, 1, 0, 16777216, 33554431);
    fill_lattice(100);
    churn(170, 100);
    wait_quiet();

    // No colours, no row offset, all weights zero: every update keeps its colour
    configure(0, 0, 2, 0, 0, 0, 0, 0);
    fill_lattice(2);
    churn(60, 2);
    wait_quiet();

    // Oversized colour count and zero site count both saturate
    configure(15, 1, 0, 16777216, 8388608, 4194304, 2097152, 1048576);
    fill_lattice(64);
    churn(130, 64);
    wait_quiet();

    configure(1, 17, 131071, 16777216, 0, 12345678, 0, 777);
    fill_lattice(128);
    churn(120, 128);
    wait_quiet();

    configure(2, 4, 16, 0, 0, 0, 0, 33554431);
    fill_lattice(16);
    churn(100, 16);
    wait_quiet();

    // Stall the result side long enough to back up the input
    configure(5, 7, 49, 100, 5000, 300000, 9000000, 16777216);
    fill_lattice(49);
    hold_req = 1'b1;
    churn(220, 49);
    wait_quiet();

    if (book.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> potts_heat_bath_site_update.f
sv/phb_pkg.sv
sv/phb_ram.sv
sv/phb_regs.sv
sv/phb_ctrl.sv
sv/phb_dp.sv
sv/potts_heat_bath_site_update.sv
tb/sv/tb.sv
